>>> rtl/plom_pkg.sv
// Package for the price-level order book matcher.
// Book geometry, operation codes, priority encoders and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package plom_pkg;

  // Book geometry: ticks split into a group index and a bit within the group
  localparam int TICK_BITS = 10;
  localparam int SUB_BITS  = 5;
  localparam int GRP_BITS  = TICK_BITS - SUB_BITS;
  localparam int SUB       = 1 << SUB_BITS;
  localparam int GROUPS    = 1 << GRP_BITS;
  localparam int LEVELS    = 1 << TICK_BITS;
  localparam int QTY_BITS  = 32;

  // Order types
  localparam logic [1:0] OP_LIMIT_SELL  = 2'd0;
  localparam logic [1:0] OP_LIMIT_BUY   = 2'd1;
  localparam logic [1:0] OP_MARKET_SELL = 2'd2;
  localparam logic [1:0] OP_MARKET_BUY  = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take a new item
    logic take_rd;   // read best opposite level
    logic take_wr;   // consume that level
    logic rest_rd;   // read own level at the limit tick
    logic rest_wr;   // add the remainder to own level
    logic out_load;  // present the result
  } plom_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stop_take;   // nothing more to match
    logic is_market;   // market order: no resting
    logic out_blocked; // result register still held
  } plom_stat_t;

  // Index of the highest set bit (0 when none)
  function automatic logic [SUB_BITS-1:0] prio_hi(input logic [SUB-1:0] v);
    logic [SUB_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < SUB; i++) begin
      if (v[i]) r = SUB_BITS'(i);
    end
    return r;
  endfunction

  // Index of the lowest set bit (0 when none)
  function automatic logic [SUB_BITS-1:0] prio_lo(input logic [SUB-1:0] v);
    logic [SUB_BITS-1:0] r;
    r = '0;
    for (int i = SUB - 1; i >= 0; i--) begin
      if (v[i]) r = SUB_BITS'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/plom_occ.sv
// Occupancy bitmap of one book side with a two-level best-level search.
// Uses plom_pkg. The group encoder is registered, so the result is
// valid once the group register has taken the updated bitmap.
`timescale 1ns / 1ps

module plom_occ (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          from_top_i,
  input  logic                          set_i,
  input  logic                          clr_i,
  input  logic [plom_pkg::TICK_BITS-1:0] wr_idx_i,
  input  logic [plom_pkg::TICK_BITS-1:0] rd_idx_i,
  output logic                          rd_bit_o,
  output logic [plom_pkg::TICK_BITS-1:0] best_o,
  output logic                          present_o
);
  import plom_pkg::*;

  logic [SUB-1:0]      word_q [GROUPS];
  logic [GROUPS-1:0]   summary;
  logic [GRP_BITS-1:0] grp_q;
  logic                any_q;
  logic [SUB-1:0]      grp_word;
  logic [SUB_BITS-1:0] sub_idx;

  // Bitmap: reset clears the whole book
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < GROUPS; g++) word_q[g] <= '0;
    end else if (set_i) begin
      word_q[wr_idx_i[TICK_BITS-1:SUB_BITS]][wr_idx_i[SUB_BITS-1:0]] <= 1'b1;
    end else if (clr_i) begin
      word_q[wr_idx_i[TICK_BITS-1:SUB_BITS]][wr_idx_i[SUB_BITS-1:0]] <= 1'b0;
    end
  end

  // Group summary
  always_comb begin
    for (int g = 0; g < GROUPS; g++) summary[g] = |word_q[g];
  end

  // First level: best group, registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
      any_q <= 1'b0;
    end else begin
      grp_q <= from_top_i ? prio_hi(summary) : prio_lo(summary);
      any_q <= |summary;
    end
  end

  // Second level: best bit inside the chosen group
  assign grp_word  = word_q[grp_q];
  assign sub_idx   = from_top_i ? prio_hi(grp_word) : prio_lo(grp_word);
  assign best_o    = any_q ? {grp_q, sub_idx} : '0;
  assign present_o = any_q;
  assign rd_bit_o  = word_q[rd_idx_i[TICK_BITS-1:SUB_BITS]][rd_idx_i[SUB_BITS-1:0]];

endmodule

>>> rtl/plom_dpath.sv
// Datapath: level quantity memories, occupancy trackers, match and rest
// arithmetic, result register. Uses plom_pkg and plom_occ.
`timescale 1ns / 1ps

module plom_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  plom_pkg::plom_cmd_t            cmd_i,
  output plom_pkg::plom_stat_t           stat_o,
  input  logic [1:0]                     operation_i,
  input  logic [plom_pkg::TICK_BITS-1:0] price_tick_i,
  input  logic [plom_pkg::QTY_BITS-1:0]  quantity_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [plom_pkg::QTY_BITS-1:0]  filled_qty_o,
  output logic [plom_pkg::QTY_BITS-1:0]  rested_qty_o,
  output logic [plom_pkg::QTY_BITS-1:0]  dropped_qty_o,
  output logic [plom_pkg::TICK_BITS-1:0] best_bid_tick_o,
  output logic                           bid_present_o,
  output logic [plom_pkg::TICK_BITS-1:0] best_ask_tick_o,
  output logic                           ask_present_o
);
  import plom_pkg::*;

  // Item registers
  logic [1:0]           op_q;
  logic [TICK_BITS-1:0] tick_q, cur_tick_q;
  logic [QTY_BITS-1:0]  want_q, filled_q, rested_q;
  logic                 rest_occ_q;

  // Level memories (contents qualified by occupancy)
  logic [QTY_BITS-1:0]  bid_mem [LEVELS];
  logic [QTY_BITS-1:0]  ask_mem [LEVELS];
  logic [QTY_BITS-1:0]  bid_rd_q, ask_rd_q;

  logic                 take_bid, is_market;
  logic [TICK_BITS-1:0] bid_best, ask_best, opp_best, raddr, waddr;
  logic                 bid_pres, ask_pres, opp_pres, bid_bit, ask_bit;
  logic                 bound_fail;
  logic [QTY_BITS-1:0]  take_lvl, rest_lvl, room, add_amt, rest_new, wdata;
  logic                 take_all;
  logic                 bid_we, ask_we;
  logic                 out_valid_q;

  // Sells take bids, buys take asks
  assign take_bid  = (op_q == OP_LIMIT_SELL) || (op_q == OP_MARKET_SELL);
  assign is_market = (op_q == OP_MARKET_SELL) || (op_q == OP_MARKET_BUY);

  plom_occ u_bid_occ (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .from_top_i (1'b1),
    .set_i      (cmd_i.rest_wr && !take_bid && (rest_new != '0)),
    .clr_i      (cmd_i.take_wr && take_bid && take_all),
    .wr_idx_i   (waddr),
    .rd_idx_i   (tick_q),
    .rd_bit_o   (bid_bit),
    .best_o     (bid_best),
    .present_o  (bid_pres)
  );

  plom_occ u_ask_occ (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .from_top_i (1'b0),
    .set_i      (cmd_i.rest_wr && take_bid && (rest_new != '0)),
    .clr_i      (cmd_i.take_wr && !take_bid && take_all),
    .wr_idx_i   (waddr),
    .rd_idx_i   (tick_q),
    .rd_bit_o   (ask_bit),
    .best_o     (ask_best),
    .present_o  (ask_pres)
  );

  // Best opposite level and the limit bound
  assign opp_best   = take_bid ? bid_best : ask_best;
  assign opp_pres   = take_bid ? bid_pres : ask_pres;
  assign bound_fail = take_bid ? (opp_best < tick_q) : (opp_best > tick_q);

  assign stat_o.stop_take   = (want_q == '0) || !opp_pres || (!is_market && bound_fail);
  assign stat_o.is_market   = is_market;
  assign stat_o.out_blocked = out_valid_q && out_stall_i;

  // Match arithmetic: partial or whole level
  assign take_lvl = take_bid ? bid_rd_q : ask_rd_q;
  assign take_all = !(want_q < take_lvl);

  // Rest arithmetic with saturation
  assign rest_lvl = rest_occ_q ? (take_bid ? ask_rd_q : bid_rd_q) : '0;
  assign room     = ~rest_lvl;
  assign add_amt  = (want_q < room) ? want_q : room;
  assign rest_new = rest_lvl + add_amt;

  // Memory addressing
  assign raddr  = cmd_i.rest_rd ? tick_q : opp_best;
  assign waddr  = cmd_i.take_wr ? cur_tick_q : tick_q;
  assign wdata  = cmd_i.take_wr ? (take_all ? '0 : take_lvl - want_q) : rest_new;
  assign bid_we = (cmd_i.take_wr && take_bid) || (cmd_i.rest_wr && !take_bid);
  assign ask_we = (cmd_i.take_wr && !take_bid) || (cmd_i.rest_wr && take_bid);

  always_ff @(posedge clk_i) begin
    if (bid_we) bid_mem[waddr] <= wdata;
    bid_rd_q <= bid_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ask_we) ask_mem[waddr] <= wdata;
    ask_rd_q <= ask_mem[raddr];
  end

  // Item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= operation_i;
      tick_q   <= price_tick_i;
      want_q   <= quantity_i;
      filled_q <= '0;
      rested_q <= '0;
    end else if (cmd_i.take_wr) begin
      if (take_all) begin
        filled_q <= filled_q + take_lvl;
        want_q   <= want_q - take_lvl;
      end else begin
        filled_q <= filled_q + want_q;
        want_q   <= '0;
      end
    end else if (cmd_i.rest_wr) begin
      rested_q <= add_amt;
    end
    if (cmd_i.take_rd) cur_tick_q <= opp_best;
    if (cmd_i.rest_rd) rest_occ_q <= take_bid ? ask_bit : bid_bit;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      filled_qty_o    <= filled_q;
      rested_qty_o    <= rested_q;
      dropped_qty_o   <= is_market ? want_q : '0;
      best_bid_tick_o <= bid_best;
      bid_present_o   <= bid_pres;
      best_ask_tick_o <= ask_best;
      ask_present_o   <= ask_pres;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/plom_ctrl.sv
// Controller state machine: sequences matching, resting and the result.
// Uses plom_pkg; drives plom_dpath through command and status structs.
`timescale 1ns / 1ps

module plom_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output plom_pkg::plom_cmd_t  cmd_o,
  input  plom_pkg::plom_stat_t stat_i
);
  import plom_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FIND    = 3'd1;
  localparam logic [2:0] S_CHECK   = 3'd2;
  localparam logic [2:0] S_TAKE    = 3'd3;
  localparam logic [2:0] S_REST_RD = 3'd4;
  localparam logic [2:0] S_REST_WR = 3'd5;
  localparam logic [2:0] S_SETTLE  = 3'd6;
  localparam logic [2:0] S_OUT     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_FIND;
        end
      end
      // search pipeline settles after the last bitmap change
      S_FIND: state_d = S_CHECK;
      S_CHECK: begin
        if (stat_i.stop_take) begin
          state_d = stat_i.is_market ? S_SETTLE : S_REST_RD;
        end else begin
          cmd_o.take_rd = 1'b1;
          state_d       = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.take_wr = 1'b1;
        state_d       = S_FIND;
      end
      S_REST_RD: begin
        cmd_o.rest_rd = 1'b1;
        state_d       = S_REST_WR;
      end
      S_REST_WR: begin
        cmd_o.rest_wr = 1'b1;
        state_d       = S_SETTLE;
      end
      S_SETTLE: state_d = S_OUT;
      S_OUT: begin
        if (!stat_i.out_blocked) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Checks
  a_accept_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_FIND))
    else $error("accepted item did not start a search");

  a_take_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAKE) |=> (state_q == S_FIND))
    else $error("level consume not followed by a new search");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && stat_i.out_blocked) |=> (state_q == S_OUT))
    else $error("result loaded over a held result");

  a_market_no_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && stat_i.is_market) |=> (state_q != S_REST_RD))
    else $error("market order went to rest");

endmodule

>>> rtl/price_level_order_book_matcher_unit.sv
// Sequence from acceptance to result for market orders: bitmap search, then for each
// opposite level consumed a registered level read and a write back;
// limit orders also read and write their own level.
// One item in flight; the next is taken the cycle after the result loads,
// also while the result waits.
// Reset (async, active low) empties the book by clearing occupancy bitmaps.
`timescale 1ns / 1ps

module price_level_order_book_matcher_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [plom_pkg::TICK_BITS-1:0] price_tick_i,
  input  logic [plom_pkg::QTY_BITS-1:0]  quantity_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [plom_pkg::QTY_BITS-1:0]  filled_qty_o,
  output logic [plom_pkg::QTY_BITS-1:0]  rested_qty_o,
  output logic [plom_pkg::QTY_BITS-1:0]  dropped_qty_o,
  output logic [plom_pkg::TICK_BITS-1:0] best_bid_tick_o,
  output logic                           bid_present_o,
  output logic [plom_pkg::TICK_BITS-1:0] best_ask_tick_o,
  output logic                           ask_present_o
);
  import plom_pkg::*;

  plom_cmd_t  cmd;
  plom_stat_t stat;

  // Sequencer
  plom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // Book storage and arithmetic
  plom_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .price_tick_i    (price_tick_i),
    .quantity_i      (quantity_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filled_qty_o    (filled_qty_o),
    .rested_qty_o    (rested_qty_o),
    .dropped_qty_o   (dropped_qty_o),
    .best_bid_tick_o (best_bid_tick_o),
    .bid_present_o   (bid_present_o),
    .best_ask_tick_o (best_ask_tick_o),
    .ask_present_o   (ask_present_o)
  );

endmodule
